/* hw/rtl/msd_pkg.sv */
// shared types, constants and lookup tables for the multiplexed seven-segment driver
// no dependencies; used by every module of the block

package msd_pkg;

    localparam int NUM_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CONV_CNT_W = 5;
    localparam int POS_W      = 4;
    localparam int DIG_W      = 4;
    localparam int SEG_W      = 8;

    localparam logic [SEG_W-1:0] BLANK_RESET = 8'hFF;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_SET     = 2'd1,
        CMD_PRINT   = 2'd2,
        CMD_REFRESH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_WRITE,
        ST_HOLD
    } state_t;

    // one frame buffer write or clear request
    typedef struct packed {
        logic             clear;
        logic             en;
        logic [POS_W-1:0] pos;
        logic [SEG_W-1:0] pattern;
    } msd_wr_t;

    // converter status towards the sequencer
    typedef struct packed {
        logic             done;
        logic             nonzero;
        logic [DIG_W-1:0] digit;
    } msd_conv_stat_t;

    // active-low pattern of a decimal digit
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] dig);
        logic [SEG_W-1:0] pat;
        unique case (dig)
            4'd0:    pat = 8'hC0;
            4'd1:    pat = 8'hF9;
            4'd2:    pat = 8'hA4;
            4'd3:    pat = 8'hB0;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h92;
            4'd6:    pat = 8'h82;
            4'd7:    pat = 8'hF8;
            4'd8:    pat = 8'h80;
            4'd9:    pat = 8'h90;
            default: pat = BLANK_RESET;
        endcase
        return pat;
    endfunction

    // one-hot select byte by scan position
    function automatic logic [SEG_W-1:0] sel_of(input logic [2:0] pos);
        logic [SEG_W-1:0] s;
        unique case (pos)
            3'd0:    s = 8'h08;
            3'd1:    s = 8'h04;
            3'd2:    s = 8'h02;
            3'd3:    s = 8'h01;
            3'd4:    s = 8'h80;
            3'd5:    s = 8'h40;
            3'd6:    s = 8'h20;
            default: s = 8'h10;
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/multiplexed_seven_segment_driver.sv */
// top level of the multiplexed seven-segment driver: command sequencer and config register
// depends on msd_pkg, msd_bin2bcd and msd_frame
//
// usage:
//   s_tuser carries the command (clear, set digit, print number, refresh tick);
//   s_tdata carries position, digit and number. cfg_valid/cfg_data write the
//   blank pattern used by clear; cfg_ready is always high.
//   only refresh produces an item on the master side: the segment byte in
//   m_tdata[7:0] and the one-hot select byte in m_tdata[15:8].
// timing:
//   clear and set digit write the frame buffer on acceptance. a refresh loads
//   a free output stage on acceptance and its item appears on m_tvalid the
//   cycle after; otherwise it waits in the hold state.
//   print number runs the bit-serial bcd converter (one input bit per cycle),
//   then writes the frame buffer once per decimal digit, up to DIGIT_COUNT.
// reset:
//   the frame buffer fills with all-ones, the scan position and the output
//   valid flag clear, and the blank pattern returns to all-ones.
// stalls:
//   a waiting output item does not block clear, set or print; a refresh that
//   arrives while it still waits is held until m_tready frees the output stage.

module multiplexed_seven_segment_driver
#(
    parameter int DIGIT_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // position [3:0], digit [7:4], number [39:8]
    input  logic [1:0]  s_tuser,    // command [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // segments [7:0], select [15:8]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [PW-1:0] WR_LAST = PW'(DIGIT_COUNT - 1);

    msd_pkg::state_t            state_reg;
    msd_pkg::state_t            state_next;
    logic [PW-1:0]              cnt_reg;
    logic [PW-1:0]              cnt_next;
    logic [msd_pkg::SEG_W-1:0]  blank_reg;

    msd_pkg::cmd_t              cmd;
    logic                       take;
    logic                       conv_start;
    logic                       conv_shift;
    msd_pkg::msd_conv_stat_t    conv_stat;
    msd_pkg::msd_wr_t           wr;
    logic                       load;
    logic                       out_free;

    assign cmd       = msd_pkg::cmd_t'(s_tuser);
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blank_reg <= msd_pkg::BLANK_RESET;
        else if (cfg_valid)
            blank_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                if (take && (cmd == msd_pkg::CMD_PRINT))
                    state_next = msd_pkg::ST_CONV;
                else if (take && (cmd == msd_pkg::CMD_REFRESH) && !out_free)
                    state_next = msd_pkg::ST_HOLD;
            end
            msd_pkg::ST_CONV:
            begin
                if (conv_stat.done)
                begin
                    state_next = msd_pkg::ST_WRITE;
                    cnt_next   = '0;
                end
            end
            msd_pkg::ST_WRITE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (!conv_stat.nonzero || (cnt_reg == WR_LAST))
                    state_next = msd_pkg::ST_IDLE;
            end
            msd_pkg::ST_HOLD:
            begin
                if (out_free)
                    state_next = msd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = msd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = 1'b0;
        conv_start = 1'b0;
        conv_shift = 1'b0;
        load       = 1'b0;
        wr.clear   = 1'b0;
        wr.en      = 1'b0;
        wr.pos     = s_tdata[3:0];
        wr.pattern = msd_pkg::seg_of(s_tdata[7:4]);
        unique case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (cmd)
                        msd_pkg::CMD_CLEAR:   wr.clear   = 1'b1;
                        msd_pkg::CMD_SET:     wr.en      = (s_tdata[7:4] <= 4'd9);
                        msd_pkg::CMD_PRINT:   conv_start = 1'b1;
                        msd_pkg::CMD_REFRESH: load       = out_free;
                        default:              wr.clear   = 1'b0;
                    endcase
                end
            end
            msd_pkg::ST_WRITE:
            begin
                // write the low digit while anything is left, then drop it
                conv_shift = 1'b1;
                wr.en      = conv_stat.nonzero;
                wr.pos     = msd_pkg::POS_W'(cnt_reg);
                wr.pattern = msd_pkg::seg_of(conv_stat.digit);
            end
            msd_pkg::ST_HOLD:
            begin
                load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    msd_bin2bcd u_conv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .number (s_tdata[39:8]),
        .shift  (conv_shift),
        .stat   (conv_stat)
    );

    msd_frame
    #(
        .DIGIT_COUNT (DIGIT_COUNT)
    )
    u_frame
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .blank    (blank_reg),
        .wr       (wr),
        .load     (load),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .out_free (out_free)
    );

endmodule

/* hw/rtl/msd_bin2bcd.sv */
// bit-serial binary to bcd converter (shift and add-3), one input bit per cycle
// afterwards drains one decimal digit per shift request; depends on msd_pkg

module msd_bin2bcd
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [msd_pkg::NUM_W-1:0]     number,
    input  logic                          shift,
    output msd_pkg::msd_conv_stat_t       stat
);

    localparam logic [msd_pkg::CONV_CNT_W-1:0] CNT_LAST =
        msd_pkg::CONV_CNT_W'(msd_pkg::NUM_W - 1);

    logic                               busy_reg;
    logic                               done_reg;
    logic [msd_pkg::CONV_CNT_W-1:0]     cnt_reg;
    logic [msd_pkg::NUM_W-1:0]          bin_reg;
    logic [msd_pkg::BCD_W-1:0]          bcd_reg;
    logic [msd_pkg::BCD_W-1:0]          bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < msd_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= number;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bcd_reg <= {bcd_adj[msd_pkg::BCD_W-2:0], bin_reg[msd_pkg::NUM_W-1]};
            bin_reg <= {bin_reg[msd_pkg::NUM_W-2:0], 1'b0};
        end
        else if (shift)
        begin
            bcd_reg <= {4'd0, bcd_reg[msd_pkg::BCD_W-1:4]};
        end
    end

    assign stat.done    = done_reg;
    assign stat.nonzero = |bcd_reg;
    assign stat.digit   = bcd_reg[3:0];

endmodule

/* hw/rtl/msd_frame.sv */
// frame buffer, scan position and registered output stage of the display driver
// depends on msd_pkg

module msd_frame
#(
    parameter int DIGIT_COUNT = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [msd_pkg::SEG_W-1:0]   blank,
    input  msd_pkg::msd_wr_t            wr,
    input  logic                        load,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [15:0]                 m_tdata,   // segments [7:0], select [15:8]
    output logic                        out_free
);

    localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [PW-1:0] SCAN_LAST = PW'(DIGIT_COUNT - 1);
    localparam logic [msd_pkg::POS_W-1:0] POS_LIMIT = msd_pkg::POS_W'(DIGIT_COUNT);

    logic [msd_pkg::SEG_W-1:0]  buf_reg [DIGIT_COUNT];
    logic [PW-1:0]              scan_reg;
    logic                       valid_reg;
    logic [msd_pkg::SEG_W-1:0]  seg_reg;
    logic [msd_pkg::SEG_W-1:0]  sel_reg;
    logic [2:0]                 scan3;

    assign scan3 = 3'(scan_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
                buf_reg[i] <= msd_pkg::BLANK_RESET;
        end
        else if (wr.clear)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
                buf_reg[i] <= blank;
        end
        else if (wr.en && (wr.pos < POS_LIMIT))
        begin
            buf_reg[wr.pos[PW-1:0]] <= wr.pattern;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                scan_reg  <= (scan_reg == SCAN_LAST) ? '0 : scan_reg + 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seg_reg <= buf_reg[scan_reg];
            sel_reg <= msd_pkg::sel_of(scan3);
        end
    end

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {sel_reg, seg_reg};

endmodule
